/* rtl/core/rfed_pkg.sv */
`timescale 1ns / 1ps

package rfed_pkg;

  // Widths of the stream payloads and configuration port.
  localparam int unsigned AltW      = 32;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 40;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] LaunchThrRst = 16'd100;
  localparam logic [CfgW-1:0] NoseOverRst  = 16'd50;
  localparam logic [CfgW-1:0] LandingRst   = 16'd500;

  // Descent minimum starts at the largest positive altitude.
  localparam logic signed [AltW-1:0] DescentStart = 32'sh7FFF_FFFF;

  // Tick counters saturate here.
  localparam logic [CfgW-1:0] CountMax = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LAUNCH_THR = 2'd0,
    CFG_NOSE_OVER  = 2'd1,
    CFG_LANDING    = 2'd2
  } cfg_idx_e;

  // Button codes; only a proper release toggles the mode.
  typedef enum logic [1:0] {
    BTN_NONE   = 2'd0,
    BTN_SHORT  = 2'd1,
    BTN_PROPER = 2'd2
  } btn_e;

  // Sticky flight flags.
  typedef struct packed {
    logic landed;
    logic apogee;
    logic launch;
  } flags_t;

endpackage

/* rtl/core/rocket_flight_event_detector_unit.sv */
`timescale 1ns / 1ps

// Rocket flight event detector.
// Each transaction on the s_axis channel is one timer tick carrying an
// altitude sample and a button event. Each tick yields exactly one
// transaction on the m_axis channel with the mode, the sticky launch,
// apogee and landing flags, the flight-end pulse and the peak rise.
// The cfg channel writes the launch threshold and the two timeouts and is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. The tick sits in the input register
// after its accepting edge, and the whole flight update runs from it into
// the output register once that is free. One tick is accepted every cycle
// while the receiver takes each result; the flight state updates per tick.
// When the receiver stalls, the output register holds and the input
// register still takes one more tick; after that s_axis_tready_o drops.
// Reset clears the mode, flags, counters, peak and ground to zero, sets the
// descent minimum to its largest value and restores the register defaults.
module rocket_flight_event_detector_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rfed_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rfed_pkg::CfgW-1:0]      cfg_data_i,
  // Tick input stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [31:0] altitude_sample, [33:32] button_event, [39:34] zero
  input  logic [rfed_pkg::InDataW-1:0]   s_axis_tdata_i,
  // Result stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] recording, [1] launched, [2] apogee_seen, [3] landed,
  // [4] flight_ended, [36:5] peak_rise, [39:37] zero
  output logic [rfed_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  import rfed_pkg::*;

  // Configuration registers.
  logic [CfgW-1:0] launch_thr_q, nose_over_q, landing_q;

  // Pipeline registers.
  logic                   in_vld_q;
  logic signed [AltW-1:0] in_alt_q;
  logic [1:0]             in_btn_q;
  logic                   out_vld_q;
  logic [OutDataW-1:0]    out_data_q;
  logic [OutDataW-1:0]    out_data_d;

  // Flight state.
  logic                   mode_q, mode_d;
  logic                   prev_q, prev_d;
  logic signed [AltW-1:0] ground_q, ground_d;
  logic signed [AltW-1:0] peak_q, peak_d;
  logic signed [AltW-1:0] low_q, low_d;
  logic [CfgW-1:0]        tsp_q, tsp_d;
  logic [CfgW-1:0]        tsl_q, tsl_d;
  flags_t                 flags_q, flags_d;

  // Handshake and pipeline advance.
  logic out_free, stage_fire, in_fire;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign stage_fire      = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_thr_q <= LaunchThrRst;
      nose_over_q  <= NoseOverRst;
      landing_q    <= LandingRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LAUNCH_THR: launch_thr_q <= cfg_data_i;
        CFG_NOSE_OVER:  nose_over_q  <= cfg_data_i;
        CFG_LANDING:    landing_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Flight update, computed from the input register and current state.
  logic                   first_tick, proper;
  logic signed [AltW-1:0] ground_b, peak_b, low_b;
  logic [CfgW-1:0]        tsp_b, tsl_b, tsp_n, tsl_n;
  flags_t                 flags_b, flags_n;
  logic signed [AltW+1:0] launch_lim, alt_ext;
  logic                   new_peak, new_low, ended;
  logic [AltW-1:0]        peak_rise;

  always_comb begin
    proper     = (in_btn_q == BTN_PROPER);
    first_tick = mode_q && !prev_q;

    // A new flight starts from the current sample.
    ground_b = first_tick ? in_alt_q : ground_q;
    peak_b   = first_tick ? in_alt_q : peak_q;
    low_b    = first_tick ? DescentStart : low_q;
    tsp_b    = first_tick ? '0 : tsp_q;
    tsl_b    = first_tick ? '0 : tsl_q;
    flags_b  = first_tick ? '0 : flags_q;

    // Launch when the sample rises above ground plus threshold.
    launch_lim = {{2{ground_b[AltW-1]}}, ground_b} + $signed({2'b00, {(AltW-CfgW){1'b0}},
                 launch_thr_q});
    alt_ext    = {{2{in_alt_q[AltW-1]}}, in_alt_q};
    flags_n        = flags_b;
    flags_n.launch = flags_b.launch || (alt_ext > launch_lim);

    // Peak tracking and nose-over timeout.
    new_peak = flags_n.launch && (in_alt_q > peak_b);
    tsp_n    = new_peak ? '0 : ((tsp_b == CountMax) ? CountMax : tsp_b + 16'd1);
    flags_n.apogee = flags_b.apogee || (flags_n.launch && (tsp_n > nose_over_q));

    // Descent minimum tracking and landing timeout.
    new_low = flags_n.apogee && (in_alt_q < low_b);
    tsl_n   = new_low ? '0 : ((tsl_b == CountMax) ? CountMax : tsl_b + 16'd1);
    flags_n.landed = flags_b.landed || (flags_n.apogee && (tsl_n > landing_q));

    // Idle ticks hold the flight state.
    ground_d = ground_q;
    peak_d   = peak_q;
    low_d    = low_q;
    tsp_d    = tsp_q;
    tsl_d    = tsl_q;
    flags_d  = flags_q;
    ended    = 1'b0;
    if (mode_q) begin
      ground_d = ground_b;
      peak_d   = new_peak ? in_alt_q : peak_b;
      low_d    = new_low ? in_alt_q : low_b;
      tsp_d    = tsp_n;
      tsl_d    = tsl_n;
      flags_d  = flags_n;
      prev_d   = 1'b1;
      mode_d   = !proper;
    end else begin
      ended  = prev_q;
      prev_d = 1'b0;
      mode_d = proper;
    end

    peak_rise  = peak_d - ground_d;
    out_data_d = {3'b000, peak_rise, ended, flags_d.landed, flags_d.apogee,
                  flags_d.launch, mode_d};
  end

  // Control and flight state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= 1'b0;
      prev_q    <= 1'b0;
      ground_q  <= '0;
      peak_q    <= '0;
      low_q     <= DescentStart;
      tsp_q     <= '0;
      tsl_q     <= '0;
      flags_q   <= '0;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (stage_fire) begin
        in_vld_q <= 1'b0;
      end
      if (stage_fire) begin
        out_vld_q <= 1'b1;
        mode_q    <= mode_d;
        prev_q    <= prev_d;
        ground_q  <= ground_d;
        peak_q    <= peak_d;
        low_q     <= low_d;
        tsp_q     <= tsp_d;
        tsl_q     <= tsl_d;
        flags_q   <= flags_d;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_alt_q <= s_axis_tdata_i[AltW-1:0];
      in_btn_q <= s_axis_tdata_i[AltW+1:AltW];
    end
    if (stage_fire) begin
      out_data_q <= out_data_d;
    end
  end

  // Landing implies apogee, and apogee implies launch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags_q.landed |-> flags_q.apogee) and (flags_q.apogee |-> flags_q.launch))
    else $error("flight flags out of order");

  // A stalled result holds steady until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |=> (out_vld_q && $stable(out_data_q)))
    else $error("result changed while stalled");

  // A new result appears only after the update stage moved an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(stage_fire))
    else $error("result without an update");

  // Input is refused only while a tick waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_vld_q && out_vld_q && !m_axis_tready_i))
    else $error("input stalled without cause");

endmodule
